// ===== sv/cha_pkg.sv =====
// Package for the convex hull area unit: sizes, payload structs and defaults.
// Depends on nothing; the top level imports it.
`default_nettype none
package cha_pkg;
    localparam int MAX_POINTS_DEFAULT = 256;
    localparam int COORD_BITS_DEFAULT = 16;
    localparam int AREA_BITS = 34;
    localparam int COUNT_BITS = 9;

    typedef struct packed {
        logic signed [COORD_BITS_DEFAULT-1:0] px;
        logic signed [COORD_BITS_DEFAULT-1:0] py;
        logic                                 last_point;
    } cha_in_t;

    typedef struct packed {
        logic [AREA_BITS-1:0]  twice_area;
        logic [COUNT_BITS-1:0] hull_count;
    } cha_out_t;
endpackage
`default_nettype wire

// ===== sv/convex_hull_area_unit.sv =====
// Top level of the convex hull area unit: point store, hull stack,
// one shared multiplier and the sequencer. Depends on cha_pkg and cha_ram.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | cha_in_t  (px, py, last_point)
//  out     | output    | out_valid/out_ready| cha_out_t (twice_area, hull_count)
//
// A point that is not last is stored, unless the store is full, and the
// unit stays ready. A last point starts a run: insertion sort (O(N^2)
// worst case), two chain passes that share the one multiplier and the
// single-port memories, and a shoelace pass. Reset clears only control state.
// in_ready is low during a run; a finished run holds in its last state
// while an earlier result still waits for out_ready.
`default_nettype none
module convex_hull_area_unit
    import cha_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire cha_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output cha_out_t      out_data
);
    localparam int COORD_BITS = COORD_BITS_DEFAULT;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int SW = $clog2(2 * MAX_POINTS);
    localparam int CW = AW + 1;
    localparam int DW = SW + 1;
    localparam int PW = 2 * COORD_BITS;
    localparam int DFW = COORD_BITS + 1;
    localparam int MW = 2 * DFW;
    localparam int ACW = MW + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_SI, S_SRD, S_SWT, S_SCMP, S_SMOV, S_SPUT,
        S_HSTART, S_HCHK, S_HR0, S_HR1, S_HW1, S_HR2, S_HW2, S_HM1, S_HM2,
        S_HDEC, S_HPUSH, S_HNEXT, S_AREA0, S_AR0, S_AW0, S_AR1, S_AW1,
        S_AM1, S_AM2, S_ANEXT, S_DONE
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg, i_reg, j_reg;
    logic [DW-1:0] depth_reg, floor_reg, k_reg;
    logic upper_reg;
    logic signed [COORD_BITS-1:0] kx_reg, ky_reg, ox_reg, oy_reg, ax_reg, ay_reg;
    logic signed [MW-1:0] prod_reg;
    logic signed [ACW-1:0] acc_reg;
    logic [AW-1:0] sa_reg, pidx_reg;
    cha_out_t res_reg;
    logic out_valid_reg;

    // Point memory and stack memory.
    logic p_we, s_we;
    logic [AW-1:0] p_addr;
    logic [PW-1:0] p_wdata, p_rdata;
    logic [SW-1:0] s_addr;
    logic [AW-1:0] s_wdata, s_rdata;

    cha_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_points (
        .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata));
    cha_ram #(.WIDTH(AW), .DEPTH(2 * MAX_POINTS)) u_stack (
        .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));

    logic signed [COORD_BITS-1:0] rx, ry;
    assign rx = p_rdata[PW-1:COORD_BITS];
    assign ry = p_rdata[COORD_BITS-1:0];

    // Shared multiplier operands.
    logic signed [DFW-1:0] ma, mb;
    logic signed [MW-1:0] mprod;
    assign mprod = ma * mb;

    logic full;
    assign full = (count_reg == CW'(MAX_POINTS));
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = res_reg;

    // Memory port and multiplier selection per state.
    always_comb
    begin
        p_we = 1'b0;
        p_addr = i_reg[AW-1:0];
        p_wdata = {kx_reg, ky_reg};
        s_we = 1'b0;
        s_addr = k_reg[SW-1:0];
        s_wdata = pidx_reg;
        ma = DFW'(ax_reg) - DFW'(ox_reg);
        mb = DFW'(ry) - DFW'(oy_reg);
        case (state_reg)
            S_IDLE:
            begin
                p_we = in_valid && in_ready && !full;
                p_addr = count_reg[AW-1:0];
                p_wdata = {in_data.px[COORD_BITS-1:0], in_data.py[COORD_BITS-1:0]};
            end
            S_SI:   p_addr = i_reg[AW-1:0];
            S_SRD, S_SCMP: p_addr = sa_reg;
            S_SMOV:
            begin
                p_we = 1'b1;
                p_addr = j_reg[AW-1:0];
                p_wdata = p_rdata;
            end
            S_SPUT:
            begin
                p_we = 1'b1;
                p_addr = j_reg[AW-1:0];
            end
            S_HR0, S_AR0, S_AR1: s_addr = k_reg[SW-1:0];
            S_HR1:
            begin
                s_addr = k_reg[SW-1:0];
                p_addr = s_rdata;
            end
            S_HW1, S_AW0, S_AW1: p_addr = s_rdata;
            S_HR2, S_HW2, S_HM1: p_addr = pidx_reg;
            S_HM2:
            begin
                ma = DFW'(ay_reg) - DFW'(oy_reg);
                mb = DFW'(rx) - DFW'(ox_reg);
            end
            S_AM1:
            begin
                p_addr = s_rdata;
                ma = DFW'(ax_reg);
                mb = DFW'(ry);
            end
            S_AM2:
            begin
                ma = DFW'(rx);
                mb = DFW'(ay_reg);
            end
            S_HPUSH:
            begin
                s_we = 1'b1;
                s_addr = depth_reg[SW-1:0];
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            depth_reg <= '0;
            acc_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        if (!full)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (in_data.last_point)
                        begin
                            i_reg <= CW'(1);
                            state_reg <= S_SI;
                        end
                    end
                end
                // Insertion sort: fetch key at i.
                S_SI:
                begin
                    if (i_reg >= count_reg)
                    begin
                        state_reg <= S_HSTART;
                    end
                    else
                    begin
                        state_reg <= S_SWT;
                        j_reg <= i_reg;
                        sa_reg <= i_reg[AW-1:0] - 1'b1;
                    end
                end
                S_SWT:
                begin
                    kx_reg <= rx;
                    ky_reg <= ry;
                    state_reg <= S_SRD;
                end
                S_SRD: state_reg <= S_SCMP;
                S_SCMP:
                begin
                    if (rx > kx_reg || (rx == kx_reg && ry > ky_reg))
                    begin
                        state_reg <= S_SMOV;
                    end
                    else
                    begin
                        state_reg <= S_SPUT;
                    end
                end
                S_SMOV:
                begin
                    j_reg <= j_reg - 1'b1;
                    if (j_reg == CW'(1))
                    begin
                        state_reg <= S_SPUT;
                    end
                    else
                    begin
                        sa_reg <= j_reg[AW-1:0] - AW'(2);
                        state_reg <= S_SRD;
                    end
                end
                S_SPUT:
                begin
                    i_reg <= i_reg + 1'b1;
                    state_reg <= S_SI;
                end
                // Chain passes.
                S_HSTART:
                begin
                    depth_reg <= '0;
                    upper_reg <= 1'b0;
                    floor_reg <= DW'(2);
                    i_reg <= '0;
                    if (count_reg <= CW'(1))
                    begin
                        pidx_reg <= '0;
                        state_reg <= (count_reg == CW'(1)) ? S_HPUSH : S_AREA0;
                    end
                    else
                    begin
                        state_reg <= S_HCHK;
                    end
                end
                S_HCHK:
                begin
                    pidx_reg <= i_reg[AW-1:0];
                    if (depth_reg >= floor_reg)
                    begin
                        k_reg <= depth_reg - DW'(2);
                        state_reg <= S_HR0;
                    end
                    else
                    begin
                        state_reg <= S_HPUSH;
                    end
                end
                S_HR0:
                begin
                    k_reg <= k_reg + 1'b1;
                    state_reg <= S_HR1;
                end
                S_HR1: state_reg <= S_HW1;
                S_HW1:
                begin
                    ox_reg <= rx;
                    oy_reg <= ry;
                    state_reg <= S_HR2;
                end
                S_HR2:
                begin
                    ax_reg <= rx;
                    ay_reg <= ry;
                    state_reg <= S_HW2;
                end
                S_HW2: state_reg <= S_HM1;
                S_HM1:
                begin
                    prod_reg <= mprod;
                    state_reg <= S_HM2;
                end
                S_HM2:
                begin
                    acc_reg <= ACW'(prod_reg) - ACW'(mprod);
                    state_reg <= S_HDEC;
                end
                S_HDEC:
                begin
                    if (acc_reg <= 0)
                    begin
                        depth_reg <= depth_reg - 1'b1;
                        state_reg <= S_HCHK;
                    end
                    else
                    begin
                        state_reg <= S_HPUSH;
                    end
                end
                S_HPUSH:
                begin
                    depth_reg <= depth_reg + 1'b1;
                    state_reg <= (count_reg <= CW'(1)) ? S_AREA0 : S_HNEXT;
                end
                S_HNEXT:
                begin
                    if (!upper_reg)
                    begin
                        if (i_reg == count_reg - 1'b1)
                        begin
                            upper_reg <= 1'b1;
                            floor_reg <= depth_reg + 1'b1;
                            i_reg <= count_reg - CW'(2);
                            state_reg <= S_HCHK;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            state_reg <= S_HCHK;
                        end
                    end
                    else if (i_reg == '0)
                    begin
                        if (depth_reg > DW'(1))
                        begin
                            depth_reg <= depth_reg - 1'b1;
                        end
                        state_reg <= S_AREA0;
                    end
                    else
                    begin
                        i_reg <= i_reg - 1'b1;
                        state_reg <= S_HCHK;
                    end
                end
                // Shoelace pass.
                S_AREA0:
                begin
                    acc_reg <= '0;
                    k_reg <= '0;
                    if (depth_reg < DW'(3))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_AR0;
                    end
                end
                S_AR0:
                begin
                    k_reg <= (k_reg + 1'b1 == depth_reg) ? '0 : k_reg + 1'b1;
                    state_reg <= S_AW0;
                end
                S_AW0: state_reg <= S_AR1;
                S_AR1:
                begin
                    ax_reg <= rx;
                    ay_reg <= ry;
                    state_reg <= S_AW1;
                end
                S_AW1: state_reg <= S_AM1;
                S_AM1:
                begin
                    acc_reg <= acc_reg + ACW'(mprod);
                    state_reg <= S_AM2;
                end
                S_AM2:
                begin
                    acc_reg <= acc_reg - ACW'(mprod);
                    state_reg <= S_ANEXT;
                end
                S_ANEXT:
                begin
                    state_reg <= (k_reg == '0) ? S_DONE : S_AR0;
                end
                // Hand the result over once the output register is free.
                S_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        res_reg.twice_area <= (depth_reg < DW'(3)) ? '0 :
                            AREA_BITS'(acc_reg[ACW-1] ? -acc_reg : acc_reg);
                        res_reg.hull_count <= COUNT_BITS'(depth_reg);
                        out_valid_reg <= 1'b1;
                        count_reg <= '0;
                        depth_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // The stack never grows beyond twice the point store.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(2 * MAX_POINTS))
        else $error("stack depth overflow");
    // A result is only raised out of the final state.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside completion");
    // A waiting result transaction keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(res_reg))
        else $error("result changed while waiting");
endmodule
`default_nettype wire

// ===== sv/cha_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module cha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write-first is not needed; read returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire
